// ===== rtl/scfp_pkg.sv =====
package scfp_pkg;

  // content store sizing
  localparam int CONTENT_DEPTH = 64;
  localparam int IDX_W         = $clog2(CONTENT_DEPTH);
  localparam int COUNT_W       = $clog2(CONTENT_DEPTH + 1);
  localparam int RAM_AW        = IDX_W + 1;
  localparam int RAM_DEPTH     = 2 * (2 ** IDX_W);

  // frame bytes
  localparam logic [7:0] HDR_BYTE = 8'hFE;
  localparam logic [7:0] END_BYTE = 8'hFA;
  localparam logic [7:0] OVERHEAD = 8'd3;

  // front parse phases
  typedef enum logic [2:0] {
    PH_HEAD1 = 3'd0,
    PH_HEAD2 = 3'd1,
    PH_LEN   = 3'd2,
    PH_ID    = 3'd3,
    PH_CMD   = 3'd4,
    PH_DATA  = 3'd5,
    PH_END   = 3'd6
  } phase_t;

  // back drain states
  typedef enum logic [1:0] {
    BK_IDLE    = 2'd0,
    BK_ISSUE   = 2'd1,
    BK_CAPTURE = 2'd2
  } back_state_t;

  // one completed frame waiting to be drained
  typedef struct packed {
    logic [7:0]         id;
    logic [7:0]         cmd;
    logic [COUNT_W-1:0] count;
    logic               bank;
  } desc_t;

endpackage

// ===== rtl/scfp_ram.sv =====
module scfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/scfp_front.sv =====
module scfp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [7:0]                  rx_byte,
  output logic                        ram_we,
  output logic [scfp_pkg::RAM_AW-1:0] ram_waddr,
  output logic [7:0]                  ram_wdata,
  output logic                        desc_push,
  output scfp_pkg::desc_t             desc
);
  import scfp_pkg::*;

  phase_t             phase, phase_next;
  logic [7:0]         prev_byte, prev_byte_next;
  logic [7:0]         decl_len, decl_len_next;
  logic [7:0]         held_id, held_id_next;
  logic [7:0]         held_cmd, held_cmd_next;
  logic [COUNT_W-1:0] fill, fill_next;
  logic               wr_bank, wr_bank_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEAD1;
      prev_byte <= '0;
      decl_len  <= '0;
      held_id   <= '0;
      held_cmd  <= '0;
      fill      <= '0;
      wr_bank   <= 1'b0;
    end else begin
      phase     <= phase_next;
      prev_byte <= prev_byte_next;
      decl_len  <= decl_len_next;
      held_id   <= held_id_next;
      held_cmd  <= held_cmd_next;
      fill      <= fill_next;
      wr_bank   <= wr_bank_next;
    end
  end

  // content goes to the bank the front currently owns
  assign ram_waddr = {wr_bank, fill[IDX_W-1:0]};
  assign ram_wdata = rx_byte;
  assign desc      = '{id: held_id, cmd: held_cmd, count: fill, bank: wr_bank};

  // frame parse
  always_comb begin
    phase_next     = phase;
    prev_byte_next = prev_byte;
    decl_len_next  = decl_len;
    held_id_next   = held_id;
    held_cmd_next  = held_cmd;
    fill_next      = fill;
    wr_bank_next   = wr_bank;
    ram_we         = 1'b0;
    desc_push      = 1'b0;
    if (in_valid) begin
      prev_byte_next = rx_byte;
      if (prev_byte == HDR_BYTE && rx_byte == HDR_BYTE) begin
        // double header restarts at the length byte
        phase_next = PH_LEN;
        fill_next  = '0;
      end else begin
        unique case (phase)
          PH_HEAD1: begin
            if (rx_byte == HDR_BYTE) phase_next = PH_HEAD2;
          end
          PH_HEAD2: begin
            phase_next = (rx_byte == HDR_BYTE) ? PH_LEN : PH_HEAD1;
          end
          PH_LEN: begin
            decl_len_next = rx_byte;
            fill_next     = '0;
            phase_next    = (rx_byte >= OVERHEAD) ? PH_ID : PH_HEAD1;
          end
          PH_ID: begin
            held_id_next = rx_byte;
            phase_next   = PH_CMD;
          end
          PH_CMD: begin
            held_cmd_next = rx_byte;
            phase_next    = (decl_len > OVERHEAD) ? PH_DATA : PH_END;
          end
          PH_DATA: begin
            if (fill < COUNT_W'(CONTENT_DEPTH)) begin
              ram_we    = 1'b1;
              fill_next = fill + COUNT_W'(1);
            end else begin
              phase_next = PH_HEAD1;
            end
            // declared content complete
            if (9'(fill_next) + 9'(OVERHEAD) >= 9'(decl_len)) phase_next = PH_END;
          end
          PH_END: begin
            if (rx_byte == END_BYTE) begin
              desc_push    = 1'b1;
              wr_bank_next = ~wr_bank;
            end
            phase_next = PH_HEAD1;
          end
          default: begin
            phase_next = PH_HEAD1;
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/scfp_fifo.sv =====
module scfp_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  scfp_pkg::desc_t push_desc,
  input  logic            pop,
  output scfp_pkg::desc_t head,
  output logic            valid,
  output logic [1:0]      count
);
  import scfp_pkg::*;

  desc_t entries [2];
  logic  wr_ptr;
  logic  rd_ptr;

  // two-entry descriptor queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  assign head  = entries[rd_ptr];
  assign valid = (count != 2'd0);

endmodule

// ===== rtl/scfp_back.sv =====
module scfp_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              desc_valid,
  input  scfp_pkg::desc_t                   desc_in,
  output logic                              desc_pop,
  output logic                              busy,
  output logic                              ram_re,
  output logic [scfp_pkg::RAM_AW-1:0]       ram_raddr,
  input  logic [7:0]                        ram_rdata,
  input  logic                              pop,
  output logic                              empty,
  output logic [7:0]                        frame_id,
  output logic [7:0]                        command,
  output logic [scfp_pkg::COUNT_W-1:0]      content_count,
  output logic [7:0]                        content_byte,
  output logic [scfp_pkg::IDX_W-1:0]        byte_index,
  output logic                              last
);
  import scfp_pkg::*;

  back_state_t      state, state_next;
  desc_t            cur;
  logic [IDX_W-1:0] idx;
  logic             out_valid;
  logic             out_take;
  logic             load;
  logic             is_last;

  assign out_take  = pop && out_valid;
  assign is_last   = (cur.count == '0) || (COUNT_W'(idx) + COUNT_W'(1) == cur.count);
  assign ram_raddr = {cur.bank, idx};
  assign busy      = (state != BK_IDLE);
  assign empty     = ~out_valid;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // drain sequencer: read one stored byte, then place it in the output register
  always_comb begin
    state_next = state;
    desc_pop   = 1'b0;
    ram_re     = 1'b0;
    load       = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (desc_valid) begin
          desc_pop   = 1'b1;
          state_next = BK_ISSUE;
        end
      end
      BK_ISSUE: begin
        if (!out_valid || out_take) begin
          ram_re     = 1'b1;
          state_next = BK_CAPTURE;
        end
      end
      BK_CAPTURE: begin
        load       = 1'b1;
        state_next = is_last ? BK_IDLE : BK_ISSUE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // current frame and byte position
  always_ff @(posedge clk) begin
    if (desc_pop) begin
      cur <= desc_in;
      idx <= '0;
    end else if (load && !is_last) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      frame_id      <= cur.id;
      command       <= cur.cmd;
      content_count <= cur.count;
      content_byte  <= (cur.count == '0) ? 8'd0 : ram_rdata;
      byte_index    <= idx;
      last          <= is_last;
    end
  end

endmodule

// ===== rtl/serial_command_frame_parser.sv =====
// Serial command frame parser. Bytes are pushed one per accepted request and
// framed as FE FE len id cmd content... FA; a double FE anywhere restarts the
// frame. Content goes into a two-bank store of 2 x 64 bytes: the front fills
// one bank while the back drains the other, so full rises only while two
// completed frames are still being drained. The back reads each stored byte
// from the store and then places it in the output register, and it issues
// the next read only once that register is empty or being popped; a frame
// with no content gives a single request with content_byte and byte_index
// zero. The last request of each frame has last set.
module serial_command_frame_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    rx_byte,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    frame_id,
  output logic [7:0]                    command,
  output logic [scfp_pkg::COUNT_W-1:0]  content_count,
  output logic [7:0]                    content_byte,
  output logic [scfp_pkg::IDX_W-1:0]    byte_index,
  output logic                          last
);
  import scfp_pkg::*;

  logic              in_valid;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [RAM_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic              desc_push;
  desc_t             push_desc;
  logic              desc_pop;
  desc_t             head_desc;
  logic              desc_valid;
  logic [1:0]        desc_count;
  logic              back_busy;

  // both banks held by queued or draining frames
  assign full     = (desc_count + 2'(back_busy)) == 2'd2;
  assign in_valid = push && !full;

  scfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .rx_byte   (rx_byte),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .desc_push (desc_push),
    .desc      (push_desc)
  );

  scfp_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  scfp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (desc_push),
    .push_desc (push_desc),
    .pop       (desc_pop),
    .head      (head_desc),
    .valid     (desc_valid),
    .count     (desc_count)
  );

  scfp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .desc_valid    (desc_valid),
    .desc_in       (head_desc),
    .desc_pop      (desc_pop),
    .busy          (back_busy),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .pop           (pop),
    .empty         (empty),
    .frame_id      (frame_id),
    .command       (command),
    .content_count (content_count),
    .content_byte  (content_byte),
    .byte_index    (byte_index),
    .last          (last)
  );

endmodule
